### hdl/asc_pkg.sv
package asc_pkg;

    // filter modes; codes five to seven keep every site
    typedef enum logic [2:0] {
        MODE_NO_UNDEFINED    = 3'd0,
        MODE_SEGREGATING     = 3'd1,
        MODE_NO_SHARING      = 3'd2,
        MODE_STRICT_NO_SHARE = 3'd3,
        MODE_SHARING         = 3'd4
    } filter_mode_t;

    // verdict reasons, first one raised wins
    typedef enum logic [2:0] {
        REASON_KEPT          = 3'd0,
        REASON_UNDEFINED     = 3'd1,
        REASON_HETEROZYGOUS  = 3'd2,
        REASON_GROUP_RULE    = 3'd3,
        REASON_SEGREGATION   = 3'd4
    } verdict_reason_t;

    // mutation class selector; code three keeps all
    localparam logic [1:0] CLASS_KEEP_ALL      = 2'd0;
    localparam logic [1:0] CLASS_TRANSITIONS   = 2'd1;
    localparam logic [1:0] CLASS_TRANSVERSIONS = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_FILTER_MODE     = 3'd0;
    localparam logic [2:0] CFG_GROUP_ONE_MASK  = 3'd1;
    localparam logic [2:0] CFG_GROUP_TWO_MASK  = 3'd2;
    localparam logic [2:0] CFG_SKIP_ROOT       = 3'd3;
    localparam logic [2:0] CFG_MUTATION_CLASS  = 3'd4;

    // base xor pattern of a transition (a<->g, c<->t)
    localparam logic [1:0] TRANSITION_XOR = 2'd2;

    // populations 0 and 1 may be skipped in no-undefined mode
    localparam logic [6:0] FIRST_CHECKED_POP = 7'd2;
    localparam logic [6:0] POSITION_MAX      = 7'd127;

    typedef struct packed {
        logic [15:0] ref_allele_count;
        logic [15:0] alt_allele_count;
        logic [1:0]  ref_base;
        logic [1:0]  alt_base;
        logic [15:0] random_draw;
        logic        last_population;
    } pop_item_t;

    typedef struct packed {
        logic        keep_site;
        logic [2:0]  verdict_reason;
    } verdict_item_t;

endpackage

### hdl/allele_site_classifier_unit.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------------
// pop      | in        | pop_valid / pop_stall   | asc_pkg::pop_item_t, one population
// verdict  | out       | verdict_valid / _stall  | asc_pkg::verdict_item_t, per site
// cfg      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one population per cycle while pop_stall is low: a request lands in the stage
// register, is classified by one 16x17 multiply and compare plus the sticky flag
// update, and moves on. a site's verdict is registered when its last request leaves
// the stage register, which is held back only while an earlier verdict still waits.
// reset (rst_n, asynchronous) clears all configuration, site state and valid bits.
// pop_stall rises only when a last population waits behind an unaccepted verdict;
// the verdict register lets the next site's populations keep flowing meanwhile.
// cfg_ready is always high; a write takes effect from the next population.
module allele_site_classifier_unit #(
    parameter int MAX_POPULATIONS = 64,
    parameter int COUNT_BITS      = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_stall,
    input  asc_pkg::pop_item_t    pop,
    output logic                  verdict_valid,
    input  logic                  verdict_stall,
    output asc_pkg::verdict_item_t verdict,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    localparam int IDX_BITS = (MAX_POPULATIONS > 1) ? $clog2(MAX_POPULATIONS) : 1;
    localparam logic [15:0] COUNT_MASK = (COUNT_BITS >= 16) ? 16'hFFFF :
        16'((32'd1 << COUNT_BITS) - 32'd1);
    localparam logic [6:0] POP_LIMIT = 7'(MAX_POPULATIONS);

    // configuration registers
    logic [2:0]                 filter_mode_reg;
    logic [MAX_POPULATIONS-1:0] group_one_mask_reg;
    logic [MAX_POPULATIONS-1:0] group_two_mask_reg;
    logic                       skip_root_reg;
    logic [1:0]                 class_select_reg;

    // stage and result registers
    logic                   stage_valid_reg, stage_valid_next;
    asc_pkg::pop_item_t     stage_reg;
    logic                   verdict_valid_reg, verdict_valid_next;
    asc_pkg::verdict_item_t verdict_reg, verdict_next;

    // site state
    logic [6:0]               pos_reg, pos_next;
    logic                     any_ref_reg, any_ref_next;
    logic                     any_alt_reg, any_alt_next;
    logic                     g1_ref_reg, g1_ref_next;
    logic                     g1_alt_reg, g1_alt_next;
    logic                     g2_ref_reg, g2_ref_next;
    logic                     g2_alt_reg, g2_alt_next;
    asc_pkg::verdict_reason_t pending_reg, pending_next;

    // datapath signals
    asc_pkg::filter_mode_t    mode;
    asc_pkg::verdict_reason_t pop_reason;
    asc_pkg::verdict_reason_t site_reason;
    logic [15:0]        ref_cnt;
    logic [15:0]        alt_cnt;
    logic               ref_nz;
    logic               alt_nz;
    logic               undefined_pop;
    logic               het_pop;
    logic [16:0]        count_sum;
    logic [32:0]        draw_product;
    logic [32:0]        ref_threshold;
    logic               pick_ref;
    logic               adds_ref;
    logic               adds_alt;
    logic               in_range;
    logic [IDX_BITS-1:0] pop_idx;
    logic               in_one;
    logic               in_two;
    logic               group_mode;
    logic               strict_mode;
    logic               checked;
    logic               transition;
    logic               load;
    logic               advance;
    logic               close_site;

    // handshakes
    assign advance    = stage_valid_reg &&
                        (!stage_reg.last_population || !verdict_valid_reg || !verdict_stall);
    assign close_site = advance && stage_reg.last_population;
    assign pop_stall  = stage_valid_reg && !advance;
    assign load       = pop_valid && !pop_stall;
    assign cfg_ready  = 1'b1;

    assign verdict_valid = verdict_valid_reg;
    assign verdict       = verdict_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg    <= 3'd0;
            group_one_mask_reg <= '0;
            group_two_mask_reg <= '0;
            skip_root_reg      <= 1'b0;
            class_select_reg   <= asc_pkg::CLASS_KEEP_ALL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                asc_pkg::CFG_FILTER_MODE:    filter_mode_reg    <= cfg_data[2:0];
                asc_pkg::CFG_GROUP_ONE_MASK: group_one_mask_reg <= cfg_data[MAX_POPULATIONS-1:0];
                asc_pkg::CFG_GROUP_TWO_MASK: group_two_mask_reg <= cfg_data[MAX_POPULATIONS-1:0];
                asc_pkg::CFG_SKIP_ROOT:      skip_root_reg      <= cfg_data[0];
                asc_pkg::CFG_MUTATION_CLASS: class_select_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // per-population classification
    always_comb
    begin
        mode          = asc_pkg::filter_mode_t'(filter_mode_reg);
        ref_cnt       = stage_reg.ref_allele_count & COUNT_MASK;
        alt_cnt       = stage_reg.alt_allele_count & COUNT_MASK;
        ref_nz        = (ref_cnt != 16'd0);
        alt_nz        = (alt_cnt != 16'd0);
        undefined_pop = !ref_nz && !alt_nz;
        het_pop       = ref_nz && alt_nz;

        // heterozygous pick: draw * (ref + alt) < ref * 65536
        count_sum     = {1'b0, ref_cnt} + {1'b0, alt_cnt};
        draw_product  = {17'd0, stage_reg.random_draw} * {16'd0, count_sum};
        ref_threshold = {1'b0, ref_cnt, 16'd0};
        pick_ref      = (draw_product < ref_threshold);
        adds_ref      = het_pop ? pick_ref  : ref_nz;
        adds_alt      = het_pop ? !pick_ref : alt_nz;

        // group membership, none past the mask width
        in_range = (pos_reg < POP_LIMIT);
        pop_idx  = pos_reg[IDX_BITS-1:0];
        in_one   = in_range && group_one_mask_reg[pop_idx];
        in_two   = in_range && group_two_mask_reg[pop_idx];

        group_mode  = (mode == asc_pkg::MODE_NO_SHARING) ||
                      (mode == asc_pkg::MODE_STRICT_NO_SHARE) ||
                      (mode == asc_pkg::MODE_SHARING);
        strict_mode = (mode == asc_pkg::MODE_STRICT_NO_SHARE);
        checked     = !skip_root_reg || (pos_reg >= asc_pkg::FIRST_CHECKED_POP);

        // rejection raised by this population alone
        pop_reason = asc_pkg::REASON_KEPT;
        if (mode == asc_pkg::MODE_NO_UNDEFINED)
        begin
            if (checked && undefined_pop)
                pop_reason = asc_pkg::REASON_UNDEFINED;
        end
        else if (group_mode && (in_one || in_two))
        begin
            if (undefined_pop)
                pop_reason = asc_pkg::REASON_UNDEFINED;
            else if (het_pop && strict_mode)
                pop_reason = asc_pkg::REASON_HETEROZYGOUS;
        end
    end

    // sticky flag and reason update
    always_comb
    begin
        any_ref_next = any_ref_reg || ref_nz;
        any_alt_next = any_alt_reg || alt_nz;
        pending_next = (pending_reg != asc_pkg::REASON_KEPT) ? pending_reg : pop_reason;

        g1_ref_next = g1_ref_reg;
        g1_alt_next = g1_alt_reg;
        g2_ref_next = g2_ref_reg;
        g2_alt_next = g2_alt_reg;
        if (group_mode && !undefined_pop && !(het_pop && strict_mode))
        begin
            if (in_one)
            begin
                g1_ref_next = g1_ref_reg || adds_ref;
                g1_alt_next = g1_alt_reg || adds_alt;
            end
            if (in_two)
            begin
                g2_ref_next = g2_ref_reg || adds_ref;
                g2_alt_next = g2_alt_reg || adds_alt;
            end
        end

        pos_next = (pos_reg < asc_pkg::POSITION_MAX) ? pos_reg + 7'd1 : pos_reg;
    end

    // site verdict from the updated state
    always_comb
    begin
        transition  = ((stage_reg.ref_base ^ stage_reg.alt_base) == asc_pkg::TRANSITION_XOR);
        site_reason = asc_pkg::REASON_KEPT;
        unique case (mode)
            asc_pkg::MODE_NO_UNDEFINED:
            begin
                site_reason = pending_next;
            end
            asc_pkg::MODE_SEGREGATING:
            begin
                if (!(any_ref_next && any_alt_next))
                    site_reason = asc_pkg::REASON_SEGREGATION;
                else if (class_select_reg == asc_pkg::CLASS_TRANSITIONS && !transition)
                    site_reason = asc_pkg::REASON_SEGREGATION;
                else if (class_select_reg == asc_pkg::CLASS_TRANSVERSIONS && transition)
                    site_reason = asc_pkg::REASON_SEGREGATION;
            end
            asc_pkg::MODE_NO_SHARING, asc_pkg::MODE_STRICT_NO_SHARE:
            begin
                if (pending_next != asc_pkg::REASON_KEPT)
                    site_reason = pending_next;
                else if ((g1_ref_next && g2_ref_next) || (g1_alt_next && g2_alt_next))
                    site_reason = asc_pkg::REASON_GROUP_RULE;
            end
            asc_pkg::MODE_SHARING:
            begin
                if (pending_next != asc_pkg::REASON_KEPT)
                    site_reason = pending_next;
                else if ((g1_ref_next != g2_ref_next) || (g1_alt_next != g2_alt_next))
                    site_reason = asc_pkg::REASON_GROUP_RULE;
            end
            default:
            begin
                site_reason = asc_pkg::REASON_KEPT;
            end
        endcase

        verdict_next.keep_site      = (site_reason == asc_pkg::REASON_KEPT);
        verdict_next.verdict_reason = site_reason;
    end

    // valid bits
    always_comb
    begin
        if (load)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;

        if (close_site)
            verdict_valid_next = 1'b1;
        else if (verdict_valid_reg && !verdict_stall)
            verdict_valid_next = 1'b0;
        else
            verdict_valid_next = verdict_valid_reg;
    end

    // control registers and site state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg   <= 1'b0;
            verdict_valid_reg <= 1'b0;
            pos_reg           <= 7'd0;
            any_ref_reg       <= 1'b0;
            any_alt_reg       <= 1'b0;
            g1_ref_reg        <= 1'b0;
            g1_alt_reg        <= 1'b0;
            g2_ref_reg        <= 1'b0;
            g2_alt_reg        <= 1'b0;
            pending_reg       <= asc_pkg::REASON_KEPT;
        end
        else
        begin
            stage_valid_reg   <= stage_valid_next;
            verdict_valid_reg <= verdict_valid_next;
            if (close_site)
            begin
                pos_reg     <= 7'd0;
                any_ref_reg <= 1'b0;
                any_alt_reg <= 1'b0;
                g1_ref_reg  <= 1'b0;
                g1_alt_reg  <= 1'b0;
                g2_ref_reg  <= 1'b0;
                g2_alt_reg  <= 1'b0;
                pending_reg <= asc_pkg::REASON_KEPT;
            end
            else if (advance)
            begin
                pos_reg     <= pos_next;
                any_ref_reg <= any_ref_next;
                any_alt_reg <= any_alt_next;
                g1_ref_reg  <= g1_ref_next;
                g1_alt_reg  <= g1_alt_next;
                g2_ref_reg  <= g2_ref_next;
                g2_alt_reg  <= g2_alt_next;
                pending_reg <= pending_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            stage_reg <= pop;
        if (close_site)
            verdict_reg <= verdict_next;
    end

    // site state is cleared once a verdict is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        close_site |=> (pos_reg == 7'd0) && (pending_reg == asc_pkg::REASON_KEPT))
        else $error("site state not cleared after verdict");

    // keep bit agrees with the reason
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid_reg |->
            (verdict_reg.keep_site == (verdict_reg.verdict_reason == asc_pkg::REASON_KEPT)))
        else $error("keep bit disagrees with verdict reason");

    // a segregation failure is never held as a pending reason
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != asc_pkg::REASON_SEGREGATION)
        else $error("segregation reason held as pending");

    // the input stalls only behind a waiting verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_stall |-> stage_valid_reg && stage_reg.last_population &&
                      verdict_valid_reg && verdict_stall)
        else $error("input stalled without a blocked verdict");

endmodule
